[rtl/mslc_pkg.sv]
package mslc_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 8;
  localparam int ID_W   = 4;

  // event kinds
  localparam logic [1:0] OP_CPU   = 2'd0;
  localparam logic [1:0] OP_GRANT = 2'd1;
  localparam logic [1:0] OP_MEM   = 2'd2;
  localparam logic [1:0] OP_SNOOP = 2'd3;

  // MESI line states
  localparam logic [1:0] ST_I = 2'd0;
  localparam logic [1:0] ST_S = 2'd1;
  localparam logic [1:0] ST_E = 2'd2;
  localparam logic [1:0] ST_M = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] addr;
    logic              is_read;
    logic [DATA_W-1:0] data_in;
    logic              shared_line;
  } mslc_in_t;

  typedef struct packed {
    logic              cpu_resp_valid;
    logic [DATA_W-1:0] cpu_resp_data;
    logic              bus_request;
    logic              bus_release;
    logic              mem_req_valid;
    logic              mem_req_is_read;
    logic              writeback_valid;
    logic [ADDR_W-1:0] bus_addr;
    logic [DATA_W-1:0] bus_data;
    logic [ID_W-1:0]   requester_id;
    logic              busy_res;
  } mslc_out_t;

endpackage

[rtl/mesi_single_line_cache_controller.sv]
// MESI snooping controller for a single cache line (tag, one data byte, dirty
// mark). Every input transaction is one event: a cpu request, a bus grant, a
// memory response or a snooped bus request, and every event yields exactly
// one result transaction, in order. The line state is read and updated by
// short compare logic in the accepting cycle and the result lands in a
// single output register, so one event per cycle is sustained and in_ready
// stays high while that register is empty or being drained. A cpu miss (or
// a write to a Shared line) asks for the bus, and further cpu requests are
// ignored until the memory response arrives; snoops are serviced while
// blocked. The cache_id register is written through the cfg channel, which
// is always ready; write it only while the block is idle.
module mesi_single_line_cache_controller (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  mslc_pkg::mslc_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mslc_pkg::mslc_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mslc_pkg::ID_W-1:0]    cfg_data
);
  import mslc_pkg::*;

  // configuration
  logic [ID_W-1:0]   cache_id_r;

  // line storage
  logic [1:0]        line_state_r, line_state_nxt;
  logic [ADDR_W-1:0] line_tag_r, line_tag_nxt;
  logic [DATA_W-1:0] line_data_r, line_data_nxt;
  logic              line_dirty_r, line_dirty_nxt;
  logic              blocked_r, blocked_nxt;

  // pending miss; only read while blocked, always written before blocking
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic              pend_is_read_r, pend_is_read_nxt;
  logic [DATA_W-1:0] pend_byte_r, pend_byte_nxt;

  // result register
  logic              out_valid_r;
  mslc_out_t         out_data_r, out_data_nxt;

  logic in_fire;
  logic hit;
  logic drop;
  logic [1:0] snoop_next;

  // take a new event whenever the result slot is free or being taken
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign hit = (line_state_r != ST_I) && (line_tag_r == in_data.addr);

  // snoop decision: Modified always drops ownership; Shared drops on a
  // snooped write; Exclusive downgrades to Shared on a snooped read and drops on a snooped write
  always_comb begin
    drop       = 1'b0;
    snoop_next = line_state_r;
    case (line_state_r)
      ST_M: begin
        drop       = 1'b1;
        snoop_next = in_data.is_read ? ST_S : ST_I;
      end
      ST_S: begin
        if (!in_data.is_read) begin
          drop       = 1'b1;
          snoop_next = ST_I;
        end
      end
      ST_E: begin
        if (in_data.is_read) begin
          snoop_next = ST_S;
        end else begin
          drop       = 1'b1;
          snoop_next = ST_I;
        end
      end
      default: begin
        drop       = 1'b0;
        snoop_next = line_state_r;
      end
    endcase
  end

  always_comb begin
    line_state_nxt   = line_state_r;
    line_tag_nxt     = line_tag_r;
    line_data_nxt    = line_data_r;
    line_dirty_nxt   = line_dirty_r;
    blocked_nxt      = blocked_r;
    pend_addr_nxt    = pend_addr_r;
    pend_is_read_nxt = pend_is_read_r;
    pend_byte_nxt    = pend_byte_r;
    out_data_nxt     = '0;

    case (in_data.opcode)
      OP_CPU: begin
        if (!blocked_r) begin
          if (hit && in_data.is_read) begin
            out_data_nxt.cpu_resp_valid = 1'b1;
            out_data_nxt.cpu_resp_data  = line_data_r;
          end else if (hit && (line_state_r != ST_S)) begin
            // write hit in E or M
            line_data_nxt               = in_data.data_in;
            line_dirty_nxt              = 1'b1;
            line_state_nxt              = ST_M;
            out_data_nxt.cpu_resp_valid = 1'b1;
          end else begin
            // miss, or upgrade of a Shared line
            if (hit) begin
              line_dirty_nxt = 1'b1;
              line_state_nxt = ST_M;
            end
            pend_addr_nxt    = in_data.addr;
            pend_is_read_nxt = in_data.is_read;
            if (!in_data.is_read) begin
              pend_byte_nxt = in_data.data_in;
            end
            blocked_nxt               = 1'b1;
            out_data_nxt.bus_request  = 1'b1;
            out_data_nxt.requester_id = cache_id_r;
          end
        end
      end
      OP_GRANT: begin
        if (blocked_r) begin
          out_data_nxt.mem_req_valid   = 1'b1;
          out_data_nxt.mem_req_is_read = pend_is_read_r;
          out_data_nxt.bus_addr        = pend_addr_r;
          out_data_nxt.bus_data        = pend_is_read_r ? '0 : pend_byte_r;
        end
      end
      OP_MEM: begin
        if (blocked_r) begin
          line_tag_nxt = in_data.addr;
          if (in_data.is_read) begin
            line_state_nxt             = in_data.shared_line ? ST_S : ST_E;
            line_data_nxt              = in_data.data_in;
            line_dirty_nxt             = 1'b0;
            out_data_nxt.cpu_resp_data = in_data.data_in;
          end else begin
            line_state_nxt = ST_M;
            line_data_nxt  = pend_byte_r;
            line_dirty_nxt = 1'b1;
          end
          out_data_nxt.cpu_resp_valid = 1'b1;
          out_data_nxt.bus_release    = 1'b1;
          out_data_nxt.requester_id   = cache_id_r;
          blocked_nxt                 = 1'b0;
        end
      end
      OP_SNOOP: begin
        if (hit) begin
          if (drop && line_dirty_r) begin
            line_dirty_nxt               = 1'b0;
            out_data_nxt.writeback_valid = 1'b1;
            out_data_nxt.bus_addr        = line_tag_r;
            out_data_nxt.bus_data        = line_data_r;
            out_data_nxt.requester_id    = cache_id_r;
          end
          line_state_nxt = snoop_next;
        end
      end
      default: begin
        line_state_nxt = line_state_r;
      end
    endcase

    out_data_nxt.busy_res = blocked_nxt;
  end

  // control and line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_id_r   <= '0;
      line_state_r <= ST_I;
      line_tag_r   <= '0;
      line_data_r  <= '0;
      line_dirty_r <= 1'b0;
      blocked_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cache_id_r <= cfg_data;
      end
      if (in_fire) begin
        line_state_r <= line_state_nxt;
        line_tag_r   <= line_tag_nxt;
        line_data_r  <= line_data_nxt;
        line_dirty_r <= line_dirty_nxt;
        blocked_r    <= blocked_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_addr_r    <= pend_addr_nxt;
      pend_is_read_r <= pend_is_read_nxt;
      pend_byte_r    <= pend_byte_nxt;
      out_data_r     <= out_data_nxt;
    end
  end

  // reported busy flag tracks the live blocked state
  a_busy_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.busy_res == blocked_r))
    else $error("busy_res disagrees with blocked state");

  // only a Modified line may be dirty
  a_dirty_mod: assert property (@(posedge clk) disable iff (!rst_n)
    line_dirty_r |-> (line_state_r == ST_M))
    else $error("dirty line outside Modified");

  // cpu request while blocked leaves the line untouched
  a_cpu_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.opcode == OP_CPU) && blocked_r) |=>
      (blocked_r && (line_state_r == $past(line_state_r)) &&
       !out_data_r.cpu_resp_valid && !out_data_r.bus_request))
    else $error("cpu request acted on while blocked");

  // a grant with nothing pending issues no memory request
  a_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.opcode == OP_GRANT) && !blocked_r) |=>
      !out_data_r.mem_req_valid)
    else $error("memory request without a pending miss");

endmodule

[tb/mesi_single_line_cache_controller_tb.sv]
module mesi_single_line_cache_controller_tb;
  import mslc_pkg::*;

  // Generous bound on the run length.
  localparam int CYCLE_LIMIT = 200000;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  mslc_in_t        in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b1;
  mslc_out_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ID_W-1:0] cfg_data  = '0;

  mesi_single_line_cache_controller i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the cache line, the pending miss and the cache id
  // ---------------------------------------------------------------------
  logic [1:0]        ln_state  = ST_I;
  logic [ADDR_W-1:0] ln_tag    = '0;
  logic [DATA_W-1:0] ln_data   = '0;
  logic              ln_dirty  = 1'b0;
  logic [ADDR_W-1:0] pend_addr = '0;
  logic              pend_rd   = 1'b0;
  logic [DATA_W-1:0] pend_byte = '0;
  logic              blocked   = 1'b0;
  logic [ID_W-1:0]   cache_id  = '0;

  mslc_in_t  event_q[$];           // events waiting to be driven
  mslc_out_t coherence_resp_q[$];  // predicted results, oldest first

  int unsigned events_sent  = 0;   // pushed into event_q
  int unsigned events_taken = 0;   // accepted by the block
  int unsigned resp_seen    = 0;
  int unsigned mismatches   = 0;
  int unsigned bad_fields   = 0;
  int unsigned cycles       = 0;

  int        in_gap    = 0;
  int        out_wait  = 0;
  int        out_draw  = 0;
  bit        in_steady  = 1'b0;    // stretch with no source idling
  bit        out_steady = 1'b0;    // stretch with no sink stalls
  mslc_out_t exp_resp;

  logic [ADDR_W-1:0] addr_pool[4];

  // Apply one event to the shadow line and queue the result it produces.
  task predict_coherence_step(input mslc_in_t ev);
    mslc_out_t  r;
    logic       hit;
    logic       drop;
    logic [1:0] nxt;
    r   = '0;
    hit = (ln_state != ST_I) && (ln_tag == ev.addr);
    case (ev.opcode)
      OP_CPU: begin
        // cpu side is ignored while a miss is outstanding
        if (!blocked) begin
          if (hit && ev.is_read) begin
            r.cpu_resp_valid = 1'b1;
            r.cpu_resp_data  = ln_data;
          end else if (hit && ln_state != ST_S) begin
            // write hit in E or M
            ln_data          = ev.data_in;
            ln_dirty         = 1'b1;
            ln_state         = ST_M;
            r.cpu_resp_valid = 1'b1;
          end else begin
            // miss, or upgrade of a Shared line
            if (hit) begin
              ln_dirty = 1'b1;
              ln_state = ST_M;
            end
            pend_addr = ev.addr;
            pend_rd   = ev.is_read;
            if (!ev.is_read) pend_byte = ev.data_in;
            blocked        = 1'b1;
            r.bus_request  = 1'b1;
            r.requester_id = cache_id;
          end
        end
      end
      OP_GRANT: begin
        if (blocked) begin
          r.mem_req_valid   = 1'b1;
          r.mem_req_is_read = pend_rd;
          r.bus_addr        = pend_addr;
          r.bus_data        = pend_rd ? '0 : pend_byte;
        end
      end
      OP_MEM: begin
        if (blocked) begin
          ln_tag = ev.addr;
          if (ev.is_read) begin
            if (ev.shared_line) ln_state = ST_S;
            else ln_state = ST_E;
            ln_data         = ev.data_in;
            ln_dirty        = 1'b0;
            r.cpu_resp_data = ev.data_in;
          end else begin
            ln_state = ST_M;
            ln_data  = pend_byte;
            ln_dirty = 1'b1;
          end
          r.cpu_resp_valid = 1'b1;
          r.bus_release    = 1'b1;
          r.requester_id   = cache_id;
          blocked          = 1'b0;
        end
      end
      default: begin
        // snoop; serviced even while blocked
        if (hit) begin
          drop = 1'b0;
          nxt  = ln_state;
          if (ln_state == ST_M) begin
            drop = 1'b1;
            if (ev.is_read) nxt = ST_S;
            else nxt = ST_I;
          end else if (ln_state == ST_S && !ev.is_read) begin
            drop = 1'b1;
            nxt  = ST_I;
          end else if (ln_state == ST_E) begin
            if (ev.is_read) begin
              nxt = ST_S;
            end else begin
              drop = 1'b1;
              nxt  = ST_I;
            end
          end
          if (drop && ln_dirty) begin
            ln_dirty          = 1'b0;
            r.writeback_valid = 1'b1;
            r.bus_addr        = ln_tag;
            r.bus_data        = ln_data;
            r.requester_id    = cache_id;
          end
          ln_state = nxt;
        end
      end
    endcase
    r.busy_res = blocked;
    coherence_resp_q.push_back(r);
  endtask

  task check_field(input string nm, input logic [31:0] e, input logic [31:0] g);
    if (g !== e) begin
      bad_fields++;
      if (mismatches < 10)
        $display("resp %0d %s: expected %0h, got %0h", resp_seen, nm, e, g);
    end
  endtask

  task push_event(input logic [1:0] op, input logic [ADDR_W-1:0] a, input logic rd,
                  input logic [DATA_W-1:0] din, input logic sh);
    mslc_in_t ev;
    ev.opcode      = op;
    ev.addr        = a;
    ev.is_read     = rd;
    ev.data_in     = din;
    ev.shared_line = sh;
    event_q.push_back(ev);
    events_sent++;
  endtask

  // Mostly a few recurring lines so that hits and snoop hits happen,
  // now and then a fully random address.
  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 7) == 0) return ADDR_W'($urandom);
    return addr_pool[2'($urandom_range(0, 3))];
  endfunction

  task queue_random_events(input int unsigned n);
    int unsigned       target;
    logic [ADDR_W-1:0] a;
    logic              rd;
    target      = events_sent + n;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = ADDR_W'($urandom);
    addr_pool[3] = ADDR_W'($urandom);
    while (events_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        // noise: any event, any content
        push_event(2'($urandom_range(0, 3)), pick_addr(), 1'($urandom),
                   DATA_W'($urandom), 1'($urandom));
      end else begin
        // well-formed miss sequence: request, grant, response, with snoops around
        a  = pick_addr();
        rd = 1'($urandom);
        push_event(OP_CPU, a, rd, DATA_W'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) == 0)
          push_event(OP_SNOOP, pick_addr(), 1'($urandom), DATA_W'($urandom),
                     1'($urandom));
        push_event(OP_GRANT, ADDR_W'($urandom), 1'($urandom), DATA_W'($urandom),
                   1'($urandom));
        if ($urandom_range(0, 3) == 0)
          push_event(OP_SNOOP, pick_addr(), 1'($urandom), DATA_W'($urandom),
                     1'($urandom));
        push_event(OP_MEM, a, rd, DATA_W'($urandom), 1'($urandom));
        if ($urandom_range(0, 2) == 0)
          push_event(OP_SNOOP, pick_addr(), 1'($urandom), DATA_W'($urandom),
                     1'($urandom));
      end
    end
  endtask

  // Only while idle: no event in flight and no result outstanding.
  task write_cache_id(input logic [ID_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cache_id = v;
  endtask

  task wait_drained();
    do @(posedge clk);
    while (events_taken != events_sent || coherence_resp_q.size() != 0);
    // registered result path
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued events, random gap after each transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if ($urandom_range(0, 31) == 0) in_steady = !in_steady;
      if (in_valid && in_ready) begin
        predict_coherence_step(in_data);
        events_taken++;
      end
      // slot is free once the current transaction is taken (or none shown)
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (event_q.size() != 0) begin
          in_data  <= event_q.pop_front();
          in_valid <= 1'b1;
          in_gap   <= in_steady ? 0 : int'($urandom_range(0, 3));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result transaction, random stall after each one
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      out_wait  <= 0;
    end else begin
      if ($urandom_range(0, 31) == 0) out_steady = !out_steady;
      if (out_valid && out_ready) begin
        if (coherence_resp_q.size() == 0) begin
          if (mismatches < 10) $display("resp %0d: no result was expected", resp_seen);
          mismatches++;
        end else begin
          exp_resp   = coherence_resp_q.pop_front();
          bad_fields = 0;
          check_field("cpu_resp_valid",  32'(exp_resp.cpu_resp_valid),
                      32'(out_data.cpu_resp_valid));
          check_field("cpu_resp_data",   32'(exp_resp.cpu_resp_data),
                      32'(out_data.cpu_resp_data));
          check_field("bus_request",     32'(exp_resp.bus_request),
                      32'(out_data.bus_request));
          check_field("bus_release",     32'(exp_resp.bus_release),
                      32'(out_data.bus_release));
          check_field("mem_req_valid",   32'(exp_resp.mem_req_valid),
                      32'(out_data.mem_req_valid));
          check_field("mem_req_is_read", 32'(exp_resp.mem_req_is_read),
                      32'(out_data.mem_req_is_read));
          check_field("writeback_valid", 32'(exp_resp.writeback_valid),
                      32'(out_data.writeback_valid));
          check_field("bus_addr",        32'(exp_resp.bus_addr),
                      32'(out_data.bus_addr));
          check_field("bus_data",        32'(exp_resp.bus_data),
                      32'(out_data.bus_data));
          check_field("requester_id",    32'(exp_resp.requester_id),
                      32'(out_data.requester_id));
          check_field("busy_res",        32'(exp_resp.busy_res),
                      32'(out_data.busy_res));
          if (bad_fields != 0) mismatches++;
        end
        resp_seen++;
        out_draw = out_steady ? 0 : int'($urandom_range(0, 3));
        out_wait  <= out_draw;
        out_ready <= (out_draw == 0);
      end else if (!out_ready) begin
        if (out_wait <= 1) out_ready <= 1'b1;
        out_wait <= out_wait - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through the MESI transitions, id at its top value
    write_cache_id(4'hF);
    push_event(OP_CPU,   32'h0000_0000, 1'b1, 8'h00, 1'b0); // read miss
    push_event(OP_CPU,   32'h0000_0000, 1'b0, 8'h11, 1'b0); // ignored: blocked
    push_event(OP_SNOOP, 32'h0000_0000, 1'b0, 8'h00, 1'b0); // snoop while blocked
    push_event(OP_GRANT, 32'h0000_0000, 1'b0, 8'h00, 1'b0); // read memory request
    push_event(OP_MEM,   32'h0000_0000, 1'b1, 8'hFF, 1'b0); // fill Exclusive
    push_event(OP_GRANT, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1); // ignored: not blocked
    push_event(OP_MEM,   32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1); // ignored: not blocked
    push_event(OP_CPU,   32'h0000_0000, 1'b1, 8'h00, 1'b0); // read hit
    push_event(OP_CPU,   32'h0000_0000, 1'b0, 8'h00, 1'b0); // write hit E -> M
    push_event(OP_SNOOP, 32'h0000_0000, 1'b1, 8'h00, 1'b0); // M: writeback, -> S
    push_event(OP_SNOOP, 32'h0000_0000, 1'b1, 8'h00, 1'b0); // S snooped read: no-op
    push_event(OP_CPU,   32'h0000_0000, 1'b0, 8'hC3, 1'b0); // S write: upgrade
    push_event(OP_GRANT, 32'h0000_0000, 1'b0, 8'h00, 1'b0); // write memory request
    push_event(OP_MEM,   32'h0000_0000, 1'b0, 8'h00, 1'b0); // complete in M
    push_event(OP_SNOOP, 32'h0000_0000, 1'b0, 8'h00, 1'b0); // M: writeback, -> I
    push_event(OP_CPU,   32'hFFFF_FFFF, 1'b1, 8'h00, 1'b1); // read miss, top addr
    push_event(OP_GRANT, 32'h0000_0000, 1'b1, 8'h00, 1'b1);
    push_event(OP_MEM,   32'hFFFF_FFFF, 1'b1, 8'hA5, 1'b1); // fill Shared
    push_event(OP_SNOOP, 32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0); // clean S -> I
    push_event(OP_SNOOP, 32'h1234_5678, 1'b0, 8'h00, 1'b0); // snoop miss
    push_event(OP_CPU,   32'h1234_5678, 1'b0, 8'h5A, 1'b0); // write miss
    push_event(OP_GRANT, 32'h0000_0000, 1'b0, 8'h00, 1'b0);
    push_event(OP_MEM,   32'h1234_5678, 1'b0, 8'h00, 1'b0); // M with written byte
    push_event(OP_CPU,   32'h1234_5678, 1'b1, 8'h00, 1'b0); // read back
    push_event(OP_SNOOP, 32'h1234_5678, 1'b1, 8'h00, 1'b0); // writeback, -> S
    wait_drained();

    // Random phases, cache id stepped through its range
    write_cache_id(4'h0);
    queue_random_events(100);
    wait_drained();
    write_cache_id(ID_W'($urandom_range(1, 14)));
    queue_random_events(100);
    wait_drained();
    write_cache_id(4'h5);
    queue_random_events(100);
    wait_drained();
    write_cache_id(4'hF);
    queue_random_events(100);
    wait_drained();

    repeat (8) @(posedge clk);
    if (coherence_resp_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
